[rtl/scc_pkg.sv]
// Shared types, codes and constants for the sector cache tag manager.
package scc_pkg;

  // Default number of cache entries.
  localparam int ENTRIES_C = 8;
  // Widths of the fixed fields.
  localparam int SECTOR_W_C = 32;
  localparam int INDEX_W_C  = 3;
  // A tag of all ones marks an empty entry.
  localparam logic [SECTOR_W_C-1:0] EMPTY_TAG_C = '1;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_MARK   = 2'd3
  } scc_op_t;

  // Input word.
  typedef struct packed {
    scc_op_t                 operation;
    logic [SECTOR_W_C-1:0]   sector;
    logic [INDEX_W_C-1:0]    entry_select;
  } scc_in_t;

  // Result word.
  typedef struct packed {
    logic [INDEX_W_C-1:0]    entry_index;
    logic                    hit;
    logic                    writeback_request;
    logic [SECTOR_W_C-1:0]   writeback_sector;
    logic                    fill_request;
    logic [SECTOR_W_C-1:0]   fill_sector;
  } scc_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_SELRD,
    ST_TAGWAIT,
    ST_UPDATE
  } scc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic sweep;
    logic sel_rd;
    logic upd;
  } scc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic victim_found;
    logic out_free;
  } scc_sts_t;

endpackage

[rtl/scc_ctrl.sv]
// Controller state machine that sequences lookup, victim search and update.
module scc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  scc_pkg::scc_op_t  in_op,
  input  scc_pkg::scc_sts_t sts,
  output scc_pkg::scc_cmd_t cmd,
  output logic              in_stall
);
  import scc_pkg::*;

  scc_state_t state_r;
  scc_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_LOOKUP: state_nxt = ST_SCAN;
            OP_ALLOC:  state_nxt = ST_SWEEP;
            default:   state_nxt = ST_SELRD;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_nxt = ST_UPDATE;
        end else if (sts.scan_done) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.victim_found) begin
          state_nxt = ST_TAGWAIT;
        end
      end
      ST_SELRD:   state_nxt = ST_TAGWAIT;
      ST_TAGWAIT: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.load    = in_valid;
      ST_SCAN:   cmd.scan_rd = 1'b1;
      ST_SWEEP:  cmd.sweep   = 1'b1;
      ST_SELRD:  cmd.sel_rd  = 1'b1;
      ST_UPDATE: cmd.upd     = sts.out_free;
      default:   cmd         = '0;
    endcase
  end

endmodule

[rtl/scc_dpath.sv]
// Datapath: tag memory, reference and dirty bits, clock hand and result register.
module scc_dpath #(
  parameter int ENTRIES = scc_pkg::ENTRIES_C
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scc_pkg::scc_in_t                in_word,
  input  logic                            cfg_wr_en,
  input  logic [scc_pkg::SECTOR_W_C-1:0]  cfg_wr_data,
  input  scc_pkg::scc_cmd_t               cmd,
  output scc_pkg::scc_sts_t               sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output scc_pkg::scc_out_t               out_word
);
  import scc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(2 * ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [SECTOR_W_C-1:0] base_r;
  scc_op_t               op_r;
  logic [SECTOR_W_C-1:0] sec_r;
  logic [INDEX_W_C-1:0]  sel_r;
  logic                  sel_ok_r;
  logic [SECTOR_W_C-1:0] key_r;
  logic [IW-1:0]         target_r;
  logic [IW-1:0]         hand_r;
  logic [CW-1:0]         scan_cnt_r;
  logic                  rd_vld_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  hit_r;
  logic [SW-1:0]         sweep_cnt_r;
  logic [ENTRIES-1:0]    ref_r;
  logic [ENTRIES-1:0]    dirty_r;
  logic [ENTRIES-1:0]    tvld_r;
  logic [SECTOR_W_C-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W_C-1:0] rdata_r;
  logic                  rvld_r;
  logic                  out_valid_r;
  scc_out_t              out_word_r;

  logic                  scan_issue;
  logic                  h_ref;
  logic                  h_dirty;
  logic                  phase1;
  logic                  exhausted;
  logic                  victim_found;
  logic [IW-1:0]         hand_inc;
  logic                  capture;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  tag_empty;
  logic                  wb_ok;
  logic                  out_free;
  logic                  match;
  logic                  write_tag;
  logic [SECTOR_W_C-1:0] new_tag;
  scc_out_t              res;

  // Scan issue, victim search decision and read port address.
  always_comb begin
    scan_issue   = cmd.scan_rd && (scan_cnt_r != CW'(ENTRIES));
    h_ref        = ref_r[hand_r];
    h_dirty      = dirty_r[hand_r];
    phase1       = (sweep_cnt_r < SW'(ENTRIES));
    exhausted    = (sweep_cnt_r == SW'(2 * ENTRIES));
    victim_found = exhausted || (phase1 ? (!h_ref && !h_dirty) : !h_dirty);
    hand_inc     = (hand_r == LAST_IDX) ? '0 : hand_r + IW'(1);
    capture      = cmd.sweep && victim_found;
    rd_en        = scan_issue || capture || cmd.sel_rd;
    if (scan_issue) begin
      rd_addr = scan_cnt_r[IW-1:0];
    end else if (capture) begin
      rd_addr = hand_r;
    end else begin
      rd_addr = target_r;
    end
  end

  // Tag checks on the word just read.
  always_comb begin
    tag_empty = !rvld_r || (rdata_r == EMPTY_TAG_C);
    wb_ok     = !tag_empty && dirty_r[target_r];
    match     = rd_vld_r && !hit_r && !tag_empty && (rdata_r == key_r);
    out_free  = !out_valid_r || !out_stall;
    write_tag = ((op_r == OP_LOOKUP) && !hit_r) || (op_r == OP_ALLOC);
    new_tag   = (op_r == OP_ALLOC) ? sec_r : key_r;
  end

  // Result word for the current operation.
  always_comb begin
    res             = '0;
    res.entry_index = INDEX_W_C'(target_r);
    case (op_r)
      OP_LOOKUP: begin
        if (hit_r) begin
          res.hit = 1'b1;
        end else begin
          res.writeback_request = wb_ok;
          if (wb_ok) begin
            res.writeback_sector = rdata_r;
          end
          res.fill_request = 1'b1;
          res.fill_sector  = key_r;
        end
      end
      OP_ALLOC: begin
        res.writeback_request = wb_ok;
        if (wb_ok) begin
          res.writeback_sector = rdata_r;
        end
      end
      OP_FLUSH: begin
        res.entry_index = sel_r;
        if (sel_ok_r && wb_ok) begin
          res.writeback_request = 1'b1;
          res.writeback_sector  = rdata_r;
        end
      end
      OP_MARK:   res.entry_index = sel_r;
      default:   res = '0;
    endcase
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.upd && write_tag) begin
      tag_mem[target_r] <= new_tag;
    end
    if (rd_en) begin
      rdata_r <= tag_mem[rd_addr];
      rvld_r  <= tvld_r[rd_addr];
    end
  end

  // Operation payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_word.operation;
      sec_r    <= in_word.sector;
      sel_r    <= in_word.entry_select;
      sel_ok_r <= (32'(in_word.entry_select) < 32'(ENTRIES));
      key_r    <= in_word.sector + base_r;
      target_r <= IW'(in_word.entry_select);
    end else if (match) begin
      target_r <= rd_idx_r;
    end else if (capture) begin
      target_r <= hand_r;
    end
    rd_idx_r <= scan_cnt_r[IW-1:0];
    if (cmd.upd) begin
      out_word_r <= res;
    end
  end

  // Control state: base register, scan and sweep counters, entry bits, hand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      hand_r      <= '0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      sweep_cnt_r <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      tvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      rd_vld_r <= scan_issue;
      if (cmd.load) begin
        scan_cnt_r  <= '0;
        sweep_cnt_r <= '0;
        hit_r       <= 1'b0;
      end else begin
        if (scan_issue) begin
          scan_cnt_r <= scan_cnt_r + CW'(1);
        end
        if (match) begin
          hit_r <= 1'b1;
        end
        if (cmd.sweep && !victim_found) begin
          sweep_cnt_r <= sweep_cnt_r + SW'(1);
        end
      end
      // One step of the clock sweep, or take the victim and step past it.
      if (cmd.sweep) begin
        if (!victim_found && phase1 && h_ref) begin
          ref_r[hand_r] <= 1'b0;
        end
        hand_r <= hand_inc;
      end
      // Entry state update when the result is written.
      if (cmd.upd) begin
        case (op_r)
          OP_LOOKUP: begin
            ref_r[target_r] <= 1'b1;
            if (!hit_r) begin
              dirty_r[target_r] <= 1'b0;
              tvld_r[target_r]  <= 1'b1;
            end
          end
          OP_ALLOC: begin
            ref_r[target_r]   <= 1'b0;
            dirty_r[target_r] <= 1'b0;
            tvld_r[target_r]  <= 1'b1;
          end
          OP_FLUSH: begin
            if (sel_ok_r) begin
              dirty_r[target_r] <= 1'b0;
            end
          end
          OP_MARK: begin
            if (sel_ok_r && !tag_empty) begin
              dirty_r[target_r] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Output register: filled on update, emptied when taken.
      if (cmd.upd) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.hit          = hit_r;
  assign sts.scan_done    = (scan_cnt_r == CW'(ENTRIES)) && !rd_vld_r;
  assign sts.victim_found = victim_found;
  assign sts.out_free     = out_free;
  assign out_valid        = out_valid_r;
  assign out_word         = out_word_r;

endmodule

[rtl/sector_cache_clock_replacement.sv]
// Top level of the sector cache tag manager with clock replacement.
//
// Input channel: in_valid/in_stall carry one word (operation, sector,
// entry_select); the word is taken at a clock edge with in_valid high and
// in_stall low. Result channel: out_valid/out_stall carry one result word
// per input word, in order. The sector base register is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while no word is in
// flight, as the block does not enforce this. Steps per word, N entries:
//   flush or mark dirty: a tag read of the selected entry;
//   lookup hit: tag scan, one memory read per cycle, up to the match;
//   lookup miss: tag scan, then at most 2N clock sweep steps, one entry
//   per cycle, then a victim tag read;
//   allocate clear: clock sweep, then a victim tag read.
// A new word is accepted in the cycle after the result is loaded, so the
// output register may still hold a stalled result while the next word is
// worked on; that word's result waits until the register is taken.
// Synchronous reset empties every entry, clears reference and dirty bits,
// the clock hand, the sector base and the output valid.
module sector_cache_clock_replacement #(
  parameter int ENTRIES = scc_pkg::ENTRIES_C
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  scc_pkg::scc_in_t                in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output scc_pkg::scc_out_t               out_word,
  input  logic                            cfg_wr_en,
  input  logic [scc_pkg::SECTOR_W_C-1:0]  cfg_wr_data
);
  import scc_pkg::*;

  scc_cmd_t cmd;
  scc_sts_t sts;

  // Sequencer.
  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.operation),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Tag store and replacement state.
  scc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

[rtl/scc_chk.sv]
// Port-level checker for the sector cache tag manager, bound to the top level.
module scc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input scc_pkg::scc_out_t out_word
);
  import scc_pkg::*;

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // A hit never asks for a fill or a writeback.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.hit |-> !out_word.fill_request && !out_word.writeback_request)
    else $error("hit reported with a memory request");

  // The writeback sector is zero unless a writeback is asked for.
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.writeback_request |-> out_word.writeback_sector == '0)
    else $error("writeback sector set without request");

  // The fill sector is zero unless a fill is asked for.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.fill_request |-> out_word.fill_sector == '0)
    else $error("fill sector set without request");

  // After a word is taken the block works on it before taking another.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted back to back");

endmodule

bind sector_cache_clock_replacement scc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
